>>> hw/rtl/psho_pkg.sv
// Shared types and constants for the perfect shuffle order block.
`timescale 1ns / 1ps
`default_nettype none

package psho_pkg;

    // Widths fixed by the request and result fields.
    localparam int POS_W   = 11;
    localparam int ORDER_W = 11;
    // The running LCM holds one extra bit so that it can mark saturation.
    localparam int ACC_W   = 12;
    localparam logic [ORDER_W-1:0] ORDER_MAX = {ORDER_W{1'b1}};
    localparam logic [ACC_W-1:0]   ACC_SAT   = {1'b1, {ORDER_W{1'b0}}};
    localparam int DIV_STEPS = ACC_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_WALK,
        S_FOLD,
        S_GCD,
        S_QUO,
        S_MUL,
        S_SAT,
        S_FINISH
    } t_state;

    // Request to the shared divider.
    typedef struct packed {
        logic               start;
        logic [ACC_W-1:0]   dividend;
        logic [POS_W-1:0]   divisor;
    } t_div_req;

    // Answer from the shared divider.
    typedef struct packed {
        logic               done;
        logic [ACC_W-1:0]   quotient;
        logic [POS_W-1:0]   remainder;
    } t_div_rsp;

endpackage

`default_nettype wire

>>> hw/rtl/psho_div.sv
// Restoring divider, one quotient bit per cycle, shared by the gcd and LCM steps.
`timescale 1ns / 1ps
`default_nettype none

module psho_div
    import psho_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_CNT_W-1:0] n_cnt;
    logic                 r_done;
    logic                 n_done;
    logic [ACC_W-1:0]     r_quo;
    logic [ACC_W-1:0]     n_quo;
    logic [POS_W-1:0]     r_rem;
    logic [POS_W-1:0]     n_rem;
    logic [POS_W-1:0]     r_dvs;
    logic [POS_W-1:0]     n_dvs;
    logic [ACC_W-1:0]     rem_shift;
    logic [ACC_W-1:0]     rem_diff;

    // One shift and trial subtract per cycle.
    assign rem_shift = {r_rem, r_quo[ACC_W-1]};
    assign rem_diff  = rem_shift - {1'b0, r_dvs};

    always_comb begin
        n_cnt  = r_cnt;
        n_done = 1'b0;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
            if (rem_shift >= {1'b0, r_dvs}) begin
                n_rem = rem_diff[POS_W-1:0];
                n_quo = {r_quo[ACC_W-2:0], 1'b1};
            end else begin
                n_rem = rem_shift[POS_W-1:0];
                n_quo = {r_quo[ACC_W-2:0], 1'b0};
            end
            if (r_cnt == DIV_CNT_W'(1)) begin
                n_done = 1'b1;
            end
        end else if (i_req.start) begin
            n_cnt = DIV_CNT_W'(DIV_STEPS);
            n_quo = i_req.dividend;
            n_rem = '0;
            n_dvs = i_req.divisor;
        end
    end

    // Control state is reset; the operands are not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

`default_nettype wire

>>> hw/rtl/perfect_shuffle_order.sv
// Perfect shuffle order: cycle walk over a visited map and LCM fold via a shared divider.
// For n cards the sequencer clears the map, scans each position, walks each position of every
// new permutation cycle, checks each permutation cycle for a fold and then finishes; an empty
// deck goes straight to finish. Each LCM update that is not skipped runs gcd passes and one
// quotient pass of the 12-step divider, then multiplies and saturates.
// One request at a time: busy is high from the accepted
// start until the result strobe. Synchronous active-low reset idles the sequencer.
`timescale 1ns / 1ps
`default_nettype none

module perfect_shuffle_order
    import psho_pkg::*;
#(
    parameter int MAX_CARDS = 1024
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [POS_W-1:0]   i_deck_size,
    input  wire logic               i_out_shuffle,
    output logic                    o_done,
    output logic [ORDER_W-1:0]      o_shuffle_order
);

    // The deck field cannot exceed its own range, so storage stops there.
    localparam int DEPTH = (MAX_CARDS < 2047) ? MAX_CARDS : 2047;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [POS_W-1:0] CAP = POS_W'(DEPTH);

    t_state               r_state;
    t_state               n_state;
    logic [POS_W-1:0]     r_n;
    logic                 r_outs;
    logic [POS_W-1:0]     r_scan;
    logic [POS_W-1:0]     r_walk;
    logic                 r_hit;
    logic [POS_W-1:0]     r_len;
    logic [POS_W-1:0]     r_last;
    logic [ACC_W-1:0]     r_acc;
    logic [POS_W-1:0]     r_gb;
    logic [POS_W-1:0]     r_q;
    logic [ACC_W+POS_W-1:0] r_prod;
    logic                 r_done;
    logic [ORDER_W-1:0]   r_order;

    logic                 mem [DEPTH];
    logic                 r_rd;
    logic                 mem_we;
    logic [AW-1:0]        mem_wa;
    logic                 mem_wd;
    logic [AW-1:0]        mem_ra;

    logic [POS_W-1:0]     n_eff;
    logic [POS_W-1:0]     scan_src;
    logic [POS_W-1:0]     walk_src;
    logic                 fold_skip;
    t_div_req             div_req;
    t_div_rsp             div_rsp;

    // Source position of the card that lands at position k after one shuffle.
    function automatic logic [POS_W-1:0] f_src(
        input logic [POS_W-1:0] k,
        input logic [POS_W-1:0] n,
        input logic             outs
    );
        logic [POS_W-1:0] h;
        logic [POS_W-1:0] lead;
        logic [POS_W-1:0] trail;
        logic [POS_W:0]   n_up;
        h     = n >> 1;
        n_up  = {1'b0, n} + 1'b1;
        lead  = outs ? '0 : h;
        trail = outs ? n_up[POS_W:1] : '0;
        if (n[0] && (k == n - 1'b1)) begin
            return lead + h;
        end
        return (k[0] ? trail : lead) + (k >> 1);
    endfunction

    assign n_eff     = (i_deck_size > CAP) ? CAP : i_deck_size;
    assign scan_src  = f_src(r_scan, r_n, r_outs);
    assign walk_src  = f_src(r_walk, r_n, r_outs);
    assign fold_skip = (r_len == POS_W'(1)) || (r_len == r_last) || r_acc[ACC_W-1];

    psho_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = (n_eff == '0) ? S_FINISH : S_CLEAR;
                end
            end
            S_CLEAR: begin
                if (r_scan == r_n - 1'b1) begin
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                n_state = (r_scan == r_n) ? S_FINISH : S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                n_state = r_rd ? S_SCAN_RD : S_WALK;
            end
            S_WALK: begin
                if (r_hit || r_rd) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                n_state = fold_skip ? S_SCAN_RD : S_GCD;
            end
            S_GCD: begin
                if (div_rsp.done && div_rsp.remainder == '0) begin
                    n_state = S_QUO;
                end
            end
            S_QUO: begin
                if (div_rsp.done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL:    n_state = S_SAT;
            S_SAT:    n_state = S_SCAN_RD;
            S_FINISH: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Memory port and divider controls.
    always_comb begin
        mem_we  = 1'b0;
        mem_wa  = r_scan[AW-1:0];
        mem_wd  = 1'b0;
        mem_ra  = r_scan[AW-1:0];
        div_req = '0;
        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
            end
            S_SCAN_CHK: begin
                if (!r_rd) begin
                    mem_we = 1'b1;
                    mem_wd = 1'b1;
                    mem_ra = scan_src[AW-1:0];
                end
            end
            S_WALK: begin
                mem_wa = r_walk[AW-1:0];
                mem_ra = walk_src[AW-1:0];
                if (!(r_hit || r_rd)) begin
                    mem_we = 1'b1;
                    mem_wd = 1'b1;
                end
            end
            S_FOLD: begin
                div_req.start    = !fold_skip;
                div_req.dividend = r_acc;
                div_req.divisor  = r_len;
            end
            S_GCD: begin
                if (div_rsp.done) begin
                    div_req.start = 1'b1;
                    if (div_rsp.remainder == '0) begin
                        div_req.dividend = {1'b0, r_len};
                        div_req.divisor  = r_gb;
                    end else begin
                        div_req.dividend = {1'b0, r_gb};
                        div_req.divisor  = div_rsp.remainder;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Visited map: one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= mem[mem_ra];
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_FINISH);
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_n    <= n_eff;
                r_outs <= i_out_shuffle;
                r_acc  <= ACC_W'(1);
                r_scan <= '0;
                r_last <= '0;
            end
            S_CLEAR: begin
                r_scan <= (r_scan == r_n - 1'b1) ? '0 : r_scan + 1'b1;
            end
            S_SCAN_CHK: begin
                if (r_rd) begin
                    r_scan <= r_scan + 1'b1;
                end else begin
                    r_walk <= scan_src;
                    r_hit  <= (scan_src == r_scan);
                    r_len  <= POS_W'(1);
                end
            end
            S_WALK: begin
                if (r_hit || r_rd) begin
                    r_scan <= r_scan + 1'b1;
                end else begin
                    r_walk <= walk_src;
                    r_hit  <= (walk_src == r_walk);
                    r_len  <= r_len + 1'b1;
                end
            end
            S_FOLD: begin
                r_gb <= r_len;
            end
            S_GCD: begin
                if (div_rsp.done && div_rsp.remainder != '0) begin
                    r_gb <= div_rsp.remainder;
                end
            end
            S_QUO: begin
                r_q <= div_rsp.quotient[POS_W-1:0];
            end
            S_MUL: begin
                r_prod <= r_acc * r_q;
            end
            S_SAT: begin
                r_acc  <= (r_prod > (ACC_W+POS_W)'(ORDER_MAX)) ? ACC_SAT
                                                              : r_prod[ACC_W-1:0];
                r_last <= r_len;
            end
            S_FINISH: begin
                r_order <= r_acc[ACC_W-1] ? ORDER_MAX : r_acc[ORDER_W-1:0];
            end
            default: begin
            end
        endcase
    end

    assign busy            = (r_state != S_IDLE);
    assign o_done          = r_done;
    assign o_shuffle_order = r_order;

endmodule

`default_nettype wire

>>> verif/tb_perfect_shuffle_order.sv
// Testbench for perfect_shuffle_order: predicts and checks the shuffle order of each request.
`timescale 1ns / 1ps

module tb_perfect_shuffle_order;
    import psho_pkg::*;

    localparam int DECK_LIMIT = 1024;
    localparam int ORDER_SAT  = 2047;
    // A request runs longer with a larger deck and with each divider pass.
    // Even every request at full size with the longest gaps stays far below this bound.
    localparam int CYCLE_LIMIT = 20000000;
    localparam int DRAIN_CYCLES = 100;
    localparam int ITEMS_PER_PHASE = 29;

    // Scoreboard: predicts the order of each accepted request and checks each strobed result.
    class order_scoreboard;
        logic [ORDER_W-1:0] expected_orders[$];
        int unsigned error_count;

        function new();
            error_count = 0;
        endfunction

        // Position in the old deck that feeds position k of the shuffled deck.
        function int unsigned source_position(int unsigned k, int unsigned n, bit outs);
            int unsigned half;
            int unsigned lead;
            int unsigned trail;
            half  = n / 2;
            lead  = outs ? 0 : half;
            trail = outs ? (n + 1) / 2 : 0;
            if ((n % 2 == 1) && (k == n - 1))
                return lead + half;
            return ((k % 2 == 1) ? trail : lead) + k / 2;
        endfunction

        function int unsigned gcd_of(int unsigned a, int unsigned b);
            int unsigned r;
            while (b != 0) begin
                r = a % b;
                a = b;
                b = r;
            end
            return a;
        endfunction

        // Walk every cycle of the permutation and fold the lengths into a saturating LCM.
        function logic [ORDER_W-1:0] predict_shuffle_order(logic [POS_W-1:0] size, logic outs);
            bit          seen [DECK_LIMIT];
            int unsigned n;
            int unsigned acc;
            int unsigned len;
            int unsigned pos;
            int unsigned g;
            foreach (seen[i]) seen[i] = 1'b0;
            n   = (size > DECK_LIMIT) ? DECK_LIMIT : size;
            acc = 1;
            for (int unsigned s = 0; s < n; s++) begin
                if (!seen[s]) begin
                    len = 0;
                    pos = s;
                    while (pos < n && !seen[pos]) begin
                        seen[pos] = 1'b1;
                        len++;
                        pos = source_position(pos, n, outs);
                    end
                    g = gcd_of(acc, len);
                    if (g == 0) g = 1;
                    acc = acc * (len / g);
                    if (acc > ORDER_SAT) acc = ORDER_SAT + 1;
                end
            end
            return (acc > ORDER_SAT) ? ORDER_SAT[ORDER_W-1:0] : acc[ORDER_W-1:0];
        endfunction

        function void note_request(logic [POS_W-1:0] size, logic outs);
            expected_orders.push_back(predict_shuffle_order(size, outs));
        endfunction

        task report_mismatch(string msg);
            $display("ERROR at %0t: %s", $realtime, msg);
            error_count++;
        endtask

        task check_order(logic [ORDER_W-1:0] got);
            logic [ORDER_W-1:0] want;
            if (expected_orders.size() == 0) begin
                report_mismatch($sformatf("shuffle_order %0d with no request pending", got));
            end else begin
                want = expected_orders.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("shuffle_order %0d, expected %0d", got, want));
            end
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic [POS_W-1:0]   i_deck_size = '0;
    logic               i_out_shuffle = 1'b0;
    logic               busy;
    logic               o_done;
    logic [ORDER_W-1:0] o_shuffle_order;
    int unsigned        cycle_count = 0;

    order_scoreboard sb = new();

    perfect_shuffle_order uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_deck_size     (i_deck_size),
        .i_out_shuffle   (i_out_shuffle),
        .o_done          (o_done),
        .o_shuffle_order (o_shuffle_order)
    );

    always #5 i_clk = ~i_clk;

    // Global watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_perfect_shuffle_order failed");
            $finish;
        end
    end

    // Result monitor: the strobe cannot be held off, so every marked cycle is a result.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            sb.check_order(o_shuffle_order);
    end

    // Present one request after a random gap and hold it until the block accepts it.
    task send_request(logic [POS_W-1:0] size, logic outs, int idle_pct);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_deck_size   <= size;
        i_out_shuffle <= outs;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        sb.note_request(size, outs);
    endtask

    // Drop start and hold off until every pending result has come back.
    task wait_all_results();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.expected_orders.size() != 0);
    endtask

    // Mostly small decks keep the run short; a few span the whole field.
    function logic [POS_W-1:0] random_deck_size();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 85)
            return POS_W'($urandom_range(64, 1));
        else if (pick < 95)
            return POS_W'($urandom_range(300, 65));
        return POS_W'($urandom_range(2047, 0));
    endfunction

    // Stimulus: directed corners, then random phases with different sender gaps.
    initial begin
        int idle_pct [4];
        logic [POS_W-1:0] corner_sizes [$];
        idle_pct = '{0, 85, 10, 0};
        // Empty deck, tiny decks, the classic 52, odd and even near the top, saturated sizes
        // and alternating bit patterns.
        corner_sizes = '{11'd0, 11'd1, 11'd2, 11'd3, 11'd52, 11'd1023, 11'd1024, 11'd1025,
                         11'd2047, 11'd1536, 11'd682, 11'd1365};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (corner_sizes[i]) begin
            send_request(corner_sizes[i], 1'b1, 0);
            send_request(corner_sizes[i], 1'b0, 0);
        end
        wait_all_results();

        foreach (idle_pct[p]) begin
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_request(random_deck_size(), 1'($urandom_range(1)), idle_pct[p]);
            wait_all_results();
        end

        // Watch for stray strobes before the verdict.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.error_count == 0 && sb.expected_orders.size() == 0)
            $display("tb_perfect_shuffle_order passed");
        else
            $display("tb_perfect_shuffle_order failed");
        $finish;
    end

endmodule
